/* rtl/core/s256h_pkg.sv */
// SHA-256 byte stream hasher: shared types, constants and round functions.
// Used by the schedule and round units and the top level.
// No dependencies.
package s256h_pkg;

  typedef logic [0:7][31:0] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // control from the sequencer to the message schedule window
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       step;
  } sched_ctl_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic load;
    logic step;
  } rnd_ctl_t;

  localparam hash_t IV_WORDS = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [5:0]  LEN_POS   = 6'd56;
  localparam logic [5:0]  LAST_POS  = 6'd63;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [0:63][31:0] k;
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[idx];
  endfunction

endpackage

/* rtl/core/s256h_if.sv */
// SHA-256 byte stream hasher: valid/ready channel interfaces for input bytes
// and digest words. No dependencies.
interface s256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface s256h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/s256h_sched.sv */
// SHA-256 message block window: collects bytes, then expands the schedule
// one word per round. Depends on s256h_pkg.
module s256h_sched (
  input  logic                  clk,
  input  s256h_pkg::sched_ctl_t ctl,
  output logic [31:0]           w_cur
);

  // word j of the window sits at bits [511-32*j -: 32]; word 0 is the oldest
  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  w_new;

  assign w_cur = win_r[511 -: 32];

  // w[i+16] = w[i] + s0(w[i+1]) + w[i+9] + s1(w[i+14])
  assign w_new = win_r[511 -: 32]
               + s256h_pkg::sml_sig0(win_r[479 -: 32])
               + win_r[223 -: 32]
               + s256h_pkg::sml_sig1(win_r[63 -: 32]);

  always_comb begin
    win_nxt = win_r;
    if (ctl.shift_byte) begin
      win_nxt = {win_r[503:0], ctl.byte_val};
    end else if (ctl.step) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* rtl/core/s256h_round.sv */
// SHA-256 round unit: the eight working variables and one compression round
// per step. Depends on s256h_pkg.
module s256h_round (
  input  logic                clk,
  input  s256h_pkg::rnd_ctl_t ctl,
  input  s256h_pkg::hash_t    cv,
  input  logic [31:0]         k,
  input  logic [31:0]         w,
  output s256h_pkg::hash_t    vars
);

  s256h_pkg::hash_t vars_r;
  s256h_pkg::hash_t vars_nxt;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      ch;
  logic [31:0]      maj;

  assign vars = vars_r;

  assign ch  = (vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]);
  assign maj = (vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]);
  assign t1  = vars_r[7] + s256h_pkg::big_sig1(vars_r[4]) + ch + k + w;
  assign t2  = s256h_pkg::big_sig0(vars_r[0]) + maj;

  always_comb begin
    vars_nxt = vars_r;
    if (ctl.load) begin
      vars_nxt = cv;
    end else if (ctl.step) begin
      vars_nxt[7] = vars_r[6];
      vars_nxt[6] = vars_r[5];
      vars_nxt[5] = vars_r[4];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[3] = vars_r[2];
      vars_nxt[2] = vars_r[1];
      vars_nxt[1] = vars_r[0];
      vars_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

endmodule

/* rtl/core/sha256_byte_stream_hasher_core.sv */
// SHA-256 over a byte stream: top level with sequencer, chaining words and
// bit length. Depends on s256h_pkg, s256h_if, s256h_sched and s256h_round.
//
// Usage: in_chan carries one item per handshake: data_byte with byte_present,
// and end_of_message to close the message (an item may carry only the end
// mark). out_chan returns the digest as eight items, word_index 0 (most
// significant) to 7, last_word set on the eighth.
// Sequence: the item that completes a 64-byte block also loads the round
// unit, then keeps the block busy for 64 rounds of the single round unit
// (one round per cycle) and a fold into the chaining words. An end item
// pads one byte per cycle up to the block end, compresses, once more when
// the marker lands at byte 56 or later, then presents the eight digest
// words, one per cycle while out_chan.ready holds.
// in_chan.ready is high only while the block waits for input; while the
// digest is stalled by out_chan.ready the block holds it and takes no input.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the length, the fill count and the sequencer; after the last digest word
// is taken the block returns to that same state for the next message.
module sha256_byte_stream_hasher_core (
  input  logic         clk,
  input  logic         rst_n,
  s256h_in_if.sink     in_chan,
  s256h_out_if.source  out_chan
);

  s256h_pkg::state_t     state_r, state_nxt;
  s256h_pkg::hash_t      cv_r, cv_nxt;
  logic [5:0]            fill_r, fill_nxt;
  logic [63:0]           len_r, len_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [2:0]            oidx_r, oidx_nxt;
  logic                  fin_r, fin_nxt;
  logic                  mark_r, mark_nxt;
  logic                  lenok_r, lenok_nxt;

  s256h_pkg::sched_ctl_t sctl;
  s256h_pkg::rnd_ctl_t   rctl;
  s256h_pkg::hash_t      vars;
  logic [31:0]           w_cur;
  logic [7:0]            len_byte;

  s256h_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  s256h_round u_round (
    .clk  (clk),
    .ctl  (rctl),
    .cv   (cv_r),
    .k    (s256h_pkg::round_k(cnt_r)),
    .w    (w_cur),
    .vars (vars)
  );

  // length bytes go out most significant first at positions 56..63
  assign len_byte = 8'(len_r >> {~fill_r[2:0], 3'b000});

  assign in_chan.ready        = (state_r == s256h_pkg::ST_IDLE);
  assign out_chan.valid       = (state_r == s256h_pkg::ST_OUT);
  assign out_chan.digest_word = cv_r[oidx_r];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    cv_nxt    = cv_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    oidx_nxt  = oidx_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    lenok_nxt = lenok_r;
    sctl      = '0;
    rctl      = '0;

    case (state_r)
      s256h_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          fin_nxt = in_chan.end_of_message;
          if (in_chan.byte_present) begin
            sctl.shift_byte = 1'b1;
            sctl.byte_val   = in_chan.data_byte;
            fill_nxt        = fill_r + 6'd1;
            len_nxt         = len_r + s256h_pkg::BYTE_BITS;
          end
          if (in_chan.byte_present && fill_r == s256h_pkg::LAST_POS) begin
            rctl.load = 1'b1;
            cnt_nxt   = '0;
            state_nxt = s256h_pkg::ST_ROUND;
          end else if (in_chan.end_of_message) begin
            state_nxt = s256h_pkg::ST_PAD;
          end
        end
      end

      s256h_pkg::ST_ROUND: begin
        rctl.step = 1'b1;
        sctl.step = 1'b1;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == s256h_pkg::LAST_POS) begin
          state_nxt = s256h_pkg::ST_FOLD;
        end
      end

      s256h_pkg::ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          cv_nxt[i] = cv_r[i] + vars[i];
        end
        fill_nxt = '0;
        if (!fin_r) begin
          state_nxt = s256h_pkg::ST_IDLE;
        end else if (mark_r && lenok_r) begin
          oidx_nxt  = '0;
          state_nxt = s256h_pkg::ST_OUT;
        end else begin
          // marker already placed: the extra block carries only zeros and length
          if (mark_r) begin
            lenok_nxt = 1'b1;
          end
          state_nxt = s256h_pkg::ST_PAD;
        end
      end

      s256h_pkg::ST_PAD: begin
        sctl.shift_byte = 1'b1;
        fill_nxt        = fill_r + 6'd1;
        if (!mark_r) begin
          sctl.byte_val = s256h_pkg::PAD_MARK;
          mark_nxt      = 1'b1;
          lenok_nxt     = (fill_r < s256h_pkg::LEN_POS);
        end else if (lenok_r && fill_r >= s256h_pkg::LEN_POS) begin
          sctl.byte_val = len_byte;
        end else begin
          sctl.byte_val = '0;
        end
        if (fill_r == s256h_pkg::LAST_POS) begin
          rctl.load = 1'b1;
          cnt_nxt   = '0;
          state_nxt = s256h_pkg::ST_ROUND;
        end
      end

      s256h_pkg::ST_OUT: begin
        if (out_chan.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_nxt    = s256h_pkg::IV_WORDS;
            fill_nxt  = '0;
            len_nxt   = '0;
            fin_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            lenok_nxt = 1'b0;
            state_nxt = s256h_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = s256h_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s256h_pkg::ST_IDLE;
      cv_r    <= s256h_pkg::IV_WORDS;
      fill_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cv_r    <= cv_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      lenok_r <= lenok_nxt;
    end
  end

endmodule
